@@ rtl/imu_cal_pkg.sv @@
// Package: payload types, register indexes and arithmetic constants for the IMU calibrator.
package imu_cal_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int NUM_AXES          = 6;
    localparam int AXIS_W            = 3;
    localparam int SAMPLE_W          = 16;
    localparam int SCALED_W          = 50;
    localparam int DEN_W             = 17;
    localparam int PROD_W            = 34;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 16;

    localparam logic [AXIS_W-1:0] FIRST_ACCEL_AXIS = 3'd3;
    localparam logic [AXIS_W-1:0] LAST_AXIS        = 3'd5;

    localparam logic signed [17:0] GYRO_NOM_MULT  = 18'sd10;
    localparam logic signed [17:0] UNIT_MULT      = 18'sd1;
    localparam logic [DEN_W-1:0]   GYRO_NOM_DEN   = 17'd164;
    localparam logic [DEN_W-1:0]   ACCEL_NOM_DEN  = 17'd8192;
    localparam logic [DEN_W-1:0]   UNIT_DEN       = 17'd1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SPEED_PLUS  = 2'd0,
        CFG_SPEED_MINUS = 2'd1,
        CFG_CAL_VALID   = 2'd2,
        CFG_UNUSED      = 2'd3
    } cfg_index_t;

    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_CONVERT = 1'b1
    } action_t;

    typedef struct packed {
        logic                       action;
        logic [AXIS_W-1:0]          axis;
        logic signed [SAMPLE_W-1:0] raw_sample;
        logic signed [SAMPLE_W-1:0] bias_value;
        logic signed [SAMPLE_W-1:0] plus_ref;
        logic signed [SAMPLE_W-1:0] minus_ref;
    } in_word_t;

    typedef struct packed {
        logic signed [SCALED_W-1:0] scaled_value;
        logic [AXIS_W-1:0]          result_axis;
        logic                       used_fallback;
    } out_word_t;

endpackage

@@ rtl/imu_axis_calibrator_top.sv @@
// Top level: calibration table, operand stages, multiplier and pipelined divider.
// Throughput: one word per cycle while the output is not stalled by m_ready.
// The quotient is formed one bit per divider stage.
// Each stage advances when it is empty or its successor advances, so bubbles collapse.
// Reset clears all valid bits, the six-entry calibration table and the configuration registers.
// Load words and words with an axis above five leave no result.
module imu_axis_calibrator_top #(
    parameter int FRACTION_BITS = imu_cal_pkg::FRACTION_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  imu_cal_pkg::in_word_t                s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output imu_cal_pkg::out_word_t               m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [imu_cal_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [imu_cal_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import imu_cal_pkg::*;

    localparam int NW = PROD_W + FRACTION_BITS;
    localparam int CW = (NW + 1 > SCALED_W) ? NW + 1 : SCALED_W;
    localparam logic [CW-1:0] POS_MAX = CW'((64'd1 << (SCALED_W - 1)) - 64'd1);
    localparam logic [CW-1:0] NEG_MAX = CW'(64'd1 << (SCALED_W - 1));

    logic signed [SAMPLE_W-1:0] speed_plus_reg, speed_minus_reg;
    logic                       cal_valid_reg;
    logic signed [SAMPLE_W-1:0] tbl_bias_reg  [NUM_AXES];
    logic signed [SAMPLE_W-1:0] tbl_plus_reg  [NUM_AXES];
    logic signed [SAMPLE_W-1:0] tbl_minus_reg [NUM_AXES];

    logic              in_accept, axis_ok;
    logic [AXIS_W-1:0] rd_idx;

    // stage 1
    logic                       v1_reg;
    logic [AXIS_W-1:0]          axis1_reg;
    logic signed [SAMPLE_W-1:0] raw1_reg, bias1_reg, plus1_reg, minus1_reg;
    // stage 2
    logic                       v2_reg;
    logic [AXIS_W-1:0]          axis2_reg;
    logic                       fb2_reg;
    logic signed [17:0]         base2_reg, mult2_reg;
    logic [DEN_W-1:0]           den2_reg;
    logic signed [17:0]         base2_next, mult2_next;
    logic [DEN_W-1:0]           den2_next;
    logic                       fb2_next;
    // stage 3
    logic                       v3_reg;
    logic [AXIS_W-1:0]          axis3_reg;
    logic                       fb3_reg;
    logic signed [35:0]         prod3_reg;
    logic [DEN_W-1:0]           den3_reg;
    // divider stages
    logic                       dv_reg   [NW+1];
    logic [AXIS_W-1:0]          daxis_reg[NW+1];
    logic                       dfb_reg  [NW+1];
    logic                       dneg_reg [NW+1];
    logic [DEN_W-1:0]           dden_reg [NW+1];
    logic [DEN_W-1:0]           drem_reg [NW+1];
    logic [NW-1:0]              dnq_reg  [NW+1];
    logic [DEN_W:0]             dtrial   [NW+1];
    logic                       dge      [NW+1];
    logic [DEN_W-1:0]           drem_next[NW+1];
    logic [NW-1:0]              dnq_next [NW+1];
    logic                       den_en   [NW+1];
    // output
    logic                       ov_reg;
    out_word_t                  out_reg, out_next;
    logic                       en_out, en1, en2, en3;

    logic signed [35:0]         prod_abs;
    logic signed [16:0]         sp_sum, pm_sum, pm_diff, raw_bias, center, raw_center;
    logic [16:0]                mag;
    logic [CW-1:0]              qx, qs;

    assign cfg_ready = 1'b1;
    assign axis_ok   = (s_data.axis <= LAST_AXIS);
    assign in_accept = s_valid && s_ready;
    assign rd_idx    = axis_ok ? s_data.axis : '0;

    // advance chain, back to front
    always_comb begin
        en_out = !ov_reg || m_ready;
        den_en[NW] = !dv_reg[NW] || en_out;
        for (int k = NW - 1; k >= 0; k--) begin
            den_en[k] = !dv_reg[k] || den_en[k+1];
        end
        en3 = !v3_reg || den_en[0];
        en2 = !v2_reg || en3;
        en1 = !v1_reg || en2;
    end
    assign s_ready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_plus_reg  <= '0;
            speed_minus_reg <= '0;
            cal_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                tbl_bias_reg[i]  <= '0;
                tbl_plus_reg[i]  <= '0;
                tbl_minus_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid) begin
                case (cfg_index_t'(cfg_index))
                    CFG_SPEED_PLUS:  speed_plus_reg  <= cfg_data;
                    CFG_SPEED_MINUS: speed_minus_reg <= cfg_data;
                    CFG_CAL_VALID:   cal_valid_reg   <= cfg_data[0];
                    default: ;
                endcase
            end
            if (in_accept && axis_ok && s_data.action == ACT_LOAD) begin
                tbl_bias_reg[rd_idx]  <= s_data.bias_value;
                tbl_plus_reg[rd_idx]  <= s_data.plus_ref;
                tbl_minus_reg[rd_idx] <= s_data.minus_ref;
            end
        end
    end

    // stage 1: capture sample and its table entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_valid && axis_ok && s_data.action == ACT_CONVERT;
        end
    end
    always_ff @(posedge aclk) begin
        if (en1) begin
            axis1_reg  <= s_data.axis;
            raw1_reg   <= s_data.raw_sample;
            bias1_reg  <= tbl_bias_reg[rd_idx];
            plus1_reg  <= tbl_plus_reg[rd_idx];
            minus1_reg <= tbl_minus_reg[rd_idx];
        end
    end

    // stage 2: operand selection
    always_comb begin
        sp_sum     = 17'(speed_plus_reg) + 17'(speed_minus_reg);
        pm_sum     = 17'(plus1_reg) + 17'(minus1_reg);
        pm_diff    = 17'(plus1_reg) - 17'(minus1_reg);
        raw_bias   = 17'(raw1_reg) - 17'(bias1_reg);
        center     = (pm_sum + (pm_sum[16] ? 17'sd1 : 17'sd0)) >>> 1;
        raw_center = 17'(raw1_reg) - center;
        mag        = pm_diff[16] ? 17'(-pm_diff) : 17'(pm_diff);
        if (!cal_valid_reg) begin
            fb2_next   = 1'b1;
            base2_next = 18'(raw1_reg);
            if (axis1_reg < FIRST_ACCEL_AXIS) begin
                mult2_next = GYRO_NOM_MULT;
                den2_next  = GYRO_NOM_DEN;
            end else begin
                mult2_next = UNIT_MULT;
                den2_next  = ACCEL_NOM_DEN;
            end
        end else if (pm_diff == '0) begin
            fb2_next   = 1'b1;
            base2_next = 18'(raw1_reg);
            mult2_next = UNIT_MULT;
            den2_next  = UNIT_DEN;
        end else if (axis1_reg < FIRST_ACCEL_AXIS) begin
            fb2_next   = 1'b0;
            base2_next = 18'(raw_bias);
            mult2_next = 18'(sp_sum);
            den2_next  = mag;
        end else begin
            fb2_next   = 1'b0;
            base2_next = {raw_center, 1'b0};
            mult2_next = UNIT_MULT;
            den2_next  = mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (en2) begin
            axis2_reg <= axis1_reg;
            fb2_reg   <= fb2_next;
            base2_reg <= base2_next;
            mult2_reg <= mult2_next;
            den2_reg  <= den2_next;
        end
        if (en3) begin
            axis3_reg <= axis2_reg;
            fb3_reg   <= fb2_reg;
            prod3_reg <= base2_reg * mult2_reg;
            den3_reg  <= den2_reg;
        end
    end

    // divider: one quotient bit per stage
    assign prod_abs = prod3_reg[35] ? -prod3_reg : prod3_reg;
    always_comb begin
        dtrial[0]    = '0;
        dge[0]       = 1'b0;
        drem_next[0] = '0;
        dnq_next[0]  = {prod_abs[PROD_W-1:0], {FRACTION_BITS{1'b0}}};
        for (int k = 1; k <= NW; k++) begin
            dtrial[k]    = {drem_reg[k-1], dnq_reg[k-1][NW-1]};
            dge[k]       = dtrial[k] >= {1'b0, dden_reg[k-1]};
            drem_next[k] = dge[k] ? DEN_W'(dtrial[k] - {1'b0, dden_reg[k-1]})
                                  : dtrial[k][DEN_W-1:0];
            dnq_next[k]  = {dnq_reg[k-1][NW-2:0], dge[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NW; k++) dv_reg[k] <= 1'b0;
        end else begin
            if (den_en[0]) dv_reg[0] <= v3_reg;
            for (int k = 1; k <= NW; k++) begin
                if (den_en[k]) dv_reg[k] <= dv_reg[k-1];
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (den_en[0]) begin
            daxis_reg[0] <= axis3_reg;
            dfb_reg[0]   <= fb3_reg;
            dneg_reg[0]  <= prod3_reg[35];
            dden_reg[0]  <= den3_reg;
            drem_reg[0]  <= drem_next[0];
            dnq_reg[0]   <= dnq_next[0];
        end
        for (int k = 1; k <= NW; k++) begin
            if (den_en[k]) begin
                daxis_reg[k] <= daxis_reg[k-1];
                dfb_reg[k]   <= dfb_reg[k-1];
                dneg_reg[k]  <= dneg_reg[k-1];
                dden_reg[k]  <= dden_reg[k-1];
                drem_reg[k]  <= drem_next[k];
                dnq_reg[k]   <= dnq_next[k];
            end
        end
    end

    // output: sign, saturate
    always_comb begin
        qx = CW'(dnq_reg[NW]);
        qs = dneg_reg[NW] ? -qx : qx;
        if (!dneg_reg[NW] && qx > POS_MAX) begin
            out_next.scaled_value = SCALED_W'(POS_MAX);
        end else if (dneg_reg[NW] && qx > NEG_MAX) begin
            out_next.scaled_value = SCALED_W'(NEG_MAX);
        end else begin
            out_next.scaled_value = qs[SCALED_W-1:0];
        end
        out_next.result_axis   = daxis_reg[NW];
        out_next.used_fallback = dfb_reg[NW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (en_out) begin
            ov_reg <= dv_reg[NW];
        end
    end
    always_ff @(posedge aclk) begin
        if (en_out) out_reg <= out_next;
    end

    assign m_valid = ov_reg;
    assign m_data  = out_reg;

endmodule

@@ tb/sv/tb_imu_axis_calibrator_top.sv @@
// Testbench for imu_axis_calibrator_top: directed table and random words checked against a predictor.
module tb_imu_axis_calibrator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import imu_cal_pkg::*;

    localparam int  LATENCY     = 3 + PROD_W + FRACTION_BITS_DEF + 1;
    localparam int  CYCLE_LIMIT = 600000;
    localparam int  RAND_PHASES = 6;
    localparam int  PHASE_WORDS = 125;
    localparam longint SCALED_HI = (64'sd1 <<< (SCALED_W - 1)) - 1;
    localparam longint SCALED_LO = -SCALED_HI - 1;

    typedef struct {
        bit         is_cfg;
        cfg_index_t reg_idx;
        logic [15:0] reg_val;
        in_word_t   word;
        bit         typed;
        out_word_t  result;
    } stim_row_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    in_word_t   s_data;
    logic       m_valid;
    logic       m_ready;
    out_word_t  m_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic signed [15:0] cal_bias  [NUM_AXES];
    logic signed [15:0] cal_plus  [NUM_AXES];
    logic signed [15:0] cal_minus [NUM_AXES];
    logic signed [15:0] speed_plus;
    logic signed [15:0] speed_minus;
    bit                 cal_on;

    out_word_t  pending_results[$];
    stim_row_t  stim_table[$];
    int         errors = 0;
    int         cycles = 0;
    bit         idle_en;
    bit         hold_req;

    imu_axis_calibrator_top u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic bit calibrate(input in_word_t w, output out_word_t r);
        longint raw;
        longint bias;
        longint plus;
        longint minus;
        longint span;
        longint val;
        bit     fb;
        r = '0;
        if (w.axis > LAST_AXIS) return 1'b0;
        if (w.action == ACT_LOAD) begin
            cal_bias[w.axis]  = w.bias_value;
            cal_plus[w.axis]  = w.plus_ref;
            cal_minus[w.axis] = w.minus_ref;
            return 1'b0;
        end
        raw   = w.raw_sample;
        bias  = cal_bias[w.axis];
        plus  = cal_plus[w.axis];
        minus = cal_minus[w.axis];
        span  = (plus > minus) ? plus - minus : minus - plus;
        fb    = 1'b0;
        if (!cal_on) begin
            fb  = 1'b1;
            val = (w.axis < FIRST_ACCEL_AXIS) ? (raw * 10 * 65536) / 164 : (raw * 65536) / 8192;
        end else if (span == 0) begin
            fb  = 1'b1;
            val = raw * 65536;
        end else if (w.axis < FIRST_ACCEL_AXIS) begin
            val = ((raw - bias) * (longint'(speed_plus) + longint'(speed_minus)) * 65536) / span;
        end else begin
            val = (2 * (raw - (plus + minus) / 2) * 65536) / span;
        end
        if (val > SCALED_HI) val = SCALED_HI;
        if (val < SCALED_LO) val = SCALED_LO;
        r.scaled_value  = val[SCALED_W-1:0];
        r.result_axis   = w.axis;
        r.used_fallback = fb;
        return 1'b1;
    endfunction

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 6) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SPEED_PLUS:  speed_plus  = val;
            CFG_SPEED_MINUS: speed_minus = val;
            CFG_CAL_VALID:   cal_on      = val[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
        out_word_t r;
        if (idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        if (calibrate(w, r)) pending_results.push_back(typed ? typed_res : r);
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word %h", $time, m_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.scaled_value !== want.scaled_value) begin
                    $display("%0t: scaled_value expected %0d actual %0d", $time,
                             want.scaled_value, m_data.scaled_value);
                    errors++;
                end
                if (m_data.result_axis !== want.result_axis) begin
                    $display("%0t: result_axis expected %0d actual %0d", $time,
                             want.result_axis, m_data.result_axis);
                    errors++;
                end
                if (m_data.used_fallback !== want.used_fallback) begin
                    $display("%0t: used_fallback expected %0b actual %0b", $time,
                             want.used_fallback, m_data.used_fallback);
                    errors++;
                end
            end
        end
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_req = 1'b0;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 10)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic in_word_t mk(input action_t act, input int ax, input int raw,
                                    input int bias, input int plus, input int minus);
        in_word_t w;
        w.action     = act;
        w.axis       = ax[AXIS_W-1:0];
        w.raw_sample = raw[15:0];
        w.bias_value = bias[15:0];
        w.plus_ref   = plus[15:0];
        w.minus_ref  = minus[15:0];
        return w;
    endfunction

    function automatic stim_row_t blank_row();
        stim_row_t row;
        row.is_cfg  = 1'b0;
        row.reg_idx = CFG_SPEED_PLUS;
        row.reg_val = '0;
        row.word    = '0;
        row.typed   = 1'b0;
        row.result  = '0;
        return row;
    endfunction

    function automatic void add_word(input in_word_t w);
        stim_row_t row;
        row = blank_row();
        row.word = w;
        stim_table.push_back(row);
    endfunction

    function automatic void add_typed(input in_word_t w, input longint val, input bit fb);
        stim_row_t row;
        row = blank_row();
        row.word = w;
        row.typed = 1'b1;
        row.result.scaled_value  = val[SCALED_W-1:0];
        row.result.result_axis   = w.axis;
        row.result.used_fallback = fb;
        stim_table.push_back(row);
    endfunction

    function automatic void add_cfg(input cfg_index_t idx, input logic [15:0] val);
        stim_row_t row;
        row = blank_row();
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        stim_table.push_back(row);
    endfunction

    function automatic logic [15:0] rnd16();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic in_word_t random_word(output bit counted);
        in_word_t w;
        int       pick;
        w.raw_sample = rnd16();
        w.bias_value = rnd16();
        w.plus_ref   = rnd16();
        w.minus_ref  = ($urandom_range(0, 7) == 0) ? w.plus_ref : rnd16();
        pick = $urandom_range(0, 99);
        counted = 1'b1;
        w.axis = AXIS_W'($urandom_range(0, LAST_AXIS));
        if (pick < 8) begin
            w.axis  = AXIS_W'($urandom_range(NUM_AXES, 7));
            counted = 1'b0;
        end
        w.action = (pick < 30) ? ACT_LOAD : ACT_CONVERT;
        return w;
    endfunction

    initial begin
        logic [15:0] sp [RAND_PHASES];
        logic [15:0] sm [RAND_PHASES];
        bit          cv [RAND_PHASES];
        in_word_t    w;
        bit          counted;
        int          sent;

        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        idle_en     = 1'b1;
        hold_req    = 1'b0;
        speed_plus  = '0;
        speed_minus = '0;
        cal_on      = 1'b0;
        for (int i = 0; i < NUM_AXES; i++) begin
            cal_bias[i]  = '0;
            cal_plus[i]  = '0;
            cal_minus[i] = '0;
        end

        add_typed(mk(ACT_CONVERT, 0, 0, 0, 0, 0), 0, 1'b1);
        add_typed(mk(ACT_CONVERT, 3, -32768, 0, 0, 0), -262144, 1'b1);
        add_typed(mk(ACT_CONVERT, 5, 32767, 0, 0, 0), 262136, 1'b1);
        add_word(mk(ACT_CONVERT, 1, 32767, 0, 0, 0));
        add_word(mk(ACT_CONVERT, 2, -32768, 0, 0, 0));
        add_word(mk(ACT_CONVERT, 6, 100, 0, 0, 0));
        add_word(mk(ACT_LOAD, 7, 0, 1, 2, 3));
        add_cfg(CFG_SPEED_PLUS, 16'h7fff);
        add_cfg(CFG_SPEED_MINUS, 16'h8000);
        add_cfg(CFG_CAL_VALID, 16'h0001);
        add_typed(mk(ACT_CONVERT, 4, 1234, 0, 0, 0), 1234 * 65536, 1'b1);
        add_word(mk(ACT_LOAD, 0, 0, -32768, 32767, -32768));
        add_word(mk(ACT_CONVERT, 0, 32767, 0, 0, 0));
        add_word(mk(ACT_LOAD, 1, 0, 5, 100, 100));
        add_typed(mk(ACT_CONVERT, 1, -7, 0, 0, 0), -7 * 65536, 1'b1);
        add_word(mk(ACT_LOAD, 3, 0, 32767, -32768, 32767));
        add_word(mk(ACT_CONVERT, 3, -32768, 0, 0, 0));
        add_word(mk(ACT_CONVERT, 3, 32767, 0, 0, 0));
        add_word(mk(ACT_LOAD, 5, 0, 0, 16384, -16383));
        add_word(mk(ACT_CONVERT, 5, 0, 0, 0, 0));
        add_word(mk(ACT_LOAD, 2, 0, 0, 1, 0));
        add_word(mk(ACT_CONVERT, 2, 32767, 0, 0, 0));
        add_word(mk(ACT_LOAD, 6, 0, 9, 9, 9));
        add_word(mk(ACT_CONVERT, 2, -32768, 0, 0, 0));

        sp = '{16'h7fff, 16'h8000, 16'h0000, 16'h1234, 16'h0000, 16'h0000};
        sm = '{16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        cv = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
        sp[2] = 16'($urandom());
        sm[2] = 16'($urandom());
        sm[3] = 16'($urandom());
        sp[5] = 16'($urandom());
        sm[5] = 16'($urandom());

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (stim_table[i]) begin
            if (stim_table[i].is_cfg) begin
                s_valid <= 1'b0;
                wait_idle();
                write_reg(stim_table[i].reg_idx, stim_table[i].reg_val);
            end else begin
                send_word(stim_table[i].word, stim_table[i].typed, stim_table[i].result);
            end
        end

        for (int p = 0; p < RAND_PHASES; p++) begin
            s_valid <= 1'b0;
            wait_idle();
            write_reg(CFG_SPEED_PLUS, sp[p]);
            write_reg(CFG_SPEED_MINUS, sm[p]);
            write_reg(CFG_CAL_VALID, {15'd0, cv[p]});
            if (p == 1) hold_req = 1'b1;
            if (p == RAND_PHASES - 1) idle_en = 1'b0;
            sent = 0;
            while (sent < PHASE_WORDS) begin
                w = random_word(counted);
                send_word(w, 1'b0, '0);
                if (counted) sent++;
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ imu_axis_calibrator_top.f @@
rtl/imu_cal_pkg.sv
rtl/imu_axis_calibrator_top.sv
tb/sv/tb_imu_axis_calibrator_top.sv
